### sv/fixed_window_rate_limiter_top_defines.svh
// assertion macros shared by the rate limiter rtl
// needs clk and rst in the scope of each use
`ifndef FIXED_WINDOW_RATE_LIMITER_TOP_DEFINES_SVH
`define FIXED_WINDOW_RATE_LIMITER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FWRL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FWRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fwrl_pkg.sv
// shared types and constants of the fixed-window rate limiter
// no dependencies
package fwrl_pkg;

  localparam int CLIENT_W = 8;
  localparam int NOW_W    = 32;
  localparam int CFG_W    = 16;
  localparam int COUNT_W  = 17;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SECONDS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REQUEST_LIMIT  = 2'd1;

  localparam logic [CFG_W-1:0] WINDOW_SECONDS_RESET = 16'd60;
  localparam logic [CFG_W-1:0] REQUEST_LIMIT_RESET  = 16'd10;

  // item operation codes
  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_CLEAR   = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } fwrl_state_t;

  // table access strobes
  typedef struct packed {
    logic rd;
    logic wr;
  } fwrl_mem_cmd_t;

endpackage

### sv/fwrl_table.sv
// client table: one-port-read, one-port-write synchronous memory
// with a clearing sweep after reset; uses fwrl_pkg
`include "fixed_window_rate_limiter_top_defines.svh"

module fwrl_table #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 50
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fwrl_pkg::fwrl_mem_cmd_t cmd,
  input  logic [ADDR_W-1:0]     rd_addr,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  logic [DATA_W-1:0]     wr_data,
  output logic [DATA_W-1:0]     rd_data,
  output logic                  busy
);
  import fwrl_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // write port, sweep has priority
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (cmd.wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, held between reads
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  `FWRL_ASSERT_NOW(a_no_read_while_clearing, busy, !cmd.rd, "table read during clearing sweep")
  `FWRL_ASSERT_NOW(a_no_write_while_clearing, busy, !cmd.wr, "table write during clearing sweep")
  `FWRL_ASSERT_NOW(a_read_write_apart, cmd.wr, !cmd.rd, "table read and write in one cycle")

endmodule

### sv/fwrl_calc.sv
// window update of one request: expiry check, count increment, saturation
// uses fwrl_pkg
module fwrl_calc #(
  parameter int TIME_BITS = 32
) (
  input  logic                        entry_valid,
  input  logic [fwrl_pkg::COUNT_W-1:0] count,
  input  logic [TIME_BITS-1:0]        begin_time,
  input  logic [TIME_BITS-1:0]        now,
  input  logic [fwrl_pkg::CFG_W-1:0]   window_seconds,
  input  logic [fwrl_pkg::CFG_W-1:0]   request_limit,
  output logic [fwrl_pkg::COUNT_W-1:0] count_next,
  output logic [TIME_BITS-1:0]        begin_next,
  output logic                        allowed
);
  import fwrl_pkg::*;

  localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  logic [TIME_BITS-1:0] elapsed;
  logic                 expired;
  logic [COUNT_W-1:0]   base;
  logic [COUNT_W:0]     inc;
  logic [COUNT_W:0]     cap;
  logic [COUNT_W:0]     sat;

  // elapsed time wraps modulo the time width; a new entry has none
  always_comb begin
    elapsed = entry_valid ? (now - begin_time) : '0;
    expired = !entry_valid || (CMP_W'(elapsed) >= CMP_W'(window_seconds));
  end

  // restart or continue the window, then count and saturate
  always_comb begin
    base       = expired ? '0 : count;
    begin_next = expired ? now : begin_time;
    inc        = (COUNT_W + 1)'(base) + 1'b1;
    cap        = (COUNT_W + 1)'(request_limit) + 1'b1;
    sat        = (inc > cap) ? cap : inc;
    count_next = sat[COUNT_W-1:0];
    allowed    = (sat <= (COUNT_W + 1)'(request_limit));
  end

endmodule

### sv/fixed_window_rate_limiter_top.sv
// top level of the fixed-window rate limiter: handshakes, config registers,
// sequencer and output register; uses fwrl_pkg, fwrl_table, fwrl_calc
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  in      | to block  | in_valid / in_stall | func, client, now_seconds
//  out     | from block| out_valid / out_stall| allowed, request_count
//  cfg     | to block  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// an item's accept beat issues the table read; the update state that follows
// updates the entry, writes it back and loads the output register.
// one table read-modify-write is in flight at a time, so no forwarding is needed.
// after reset a sweep clearing all CLIENTS entries runs before the first item.
// a stalled result holds the update cycle; the table read data is kept meanwhile.
// cfg writes are taken every cycle.
`include "fixed_window_rate_limiter_top_defines.svh"

module fixed_window_rate_limiter_top #(
  parameter int CLIENTS   = 256,
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // item input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            func,
  input  logic [fwrl_pkg::CLIENT_W-1:0]   client,
  input  logic [fwrl_pkg::NOW_W-1:0]      now_seconds,
  // result output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            allowed,
  output logic [fwrl_pkg::COUNT_W-1:0]    request_count,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fwrl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fwrl_pkg::CFG_W-1:0]      cfg_data
);
  import fwrl_pkg::*;

  localparam int IDX_W    = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int ENTRY_W  = 1 + COUNT_W + TIME_BITS;
  localparam int CLIENT_N = 1 << CLIENT_W;

  typedef logic [CLIENT_N-1:0][IDX_W-1:0] idx_table_t;

  fwrl_state_t state, state_next;

  logic [CFG_W-1:0]     window_seconds;
  logic [CFG_W-1:0]     request_limit;

  logic                 func_q;
  logic [IDX_W-1:0]     idx_q;
  logic [TIME_BITS-1:0] now_q;
  logic [IDX_W-1:0]     idx_in;

  fwrl_mem_cmd_t        mem_cmd;
  logic [ENTRY_W-1:0]   rd_entry;
  logic [ENTRY_W-1:0]   wr_entry;
  logic                 table_busy;

  logic                 accept;
  logic                 out_free;

  logic [COUNT_W-1:0]   count_next;
  logic [TIME_BITS-1:0] begin_next;
  logic                 calc_allowed;

  // constant lookup of every client number modulo the table depth
  function automatic idx_table_t build_idx_table();
    idx_table_t t;
    for (int c = 0; c < CLIENT_N; c++) begin
      t[c] = IDX_W'(c % CLIENTS);
    end
    return t;
  endfunction

  localparam idx_table_t IDX_TABLE = build_idx_table();

  // client index modulo the table depth
  assign idx_in = IDX_TABLE[client];

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= WINDOW_SECONDS_RESET;
      request_limit  <= REQUEST_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW_SECONDS: window_seconds <= cfg_data;
        CFG_REQUEST_LIMIT:  request_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state and table strobes
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    mem_cmd    = '0;
    accept     = 1'b0;
    out_free   = !out_valid || !out_stall;
    unique case (state)
      ST_CLEAR: begin
        if (!table_busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall   = 1'b0;
        accept     = in_valid;
        mem_cmd.rd = in_valid;
        if (in_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          mem_cmd.wr = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // item capture on the accept beat
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func;
      idx_q  <= idx_in;
      now_q  <= TIME_BITS'(now_seconds);
    end
  end

  fwrl_table #(
    .DEPTH  (CLIENTS),
    .ADDR_W (IDX_W),
    .DATA_W (ENTRY_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .cmd     (mem_cmd),
    .rd_addr (idx_in),
    .wr_addr (idx_q),
    .wr_data (wr_entry),
    .rd_data (rd_entry),
    .busy    (table_busy)
  );

  fwrl_calc #(
    .TIME_BITS (TIME_BITS)
  ) u_calc (
    .entry_valid    (rd_entry[ENTRY_W-1]),
    .count          (rd_entry[TIME_BITS +: COUNT_W]),
    .begin_time     (rd_entry[TIME_BITS-1:0]),
    .now            (now_q),
    .window_seconds (window_seconds),
    .request_limit  (request_limit),
    .count_next     (count_next),
    .begin_next     (begin_next),
    .allowed        (calc_allowed)
  );

  // write-back word; a clear drops the valid mark
  always_comb begin
    if (func_q == FUNC_CLEAR) begin
      wr_entry = '0;
    end else begin
      wr_entry = {1'b1, count_next, begin_next};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mem_cmd.wr) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_cmd.wr) begin
      allowed       <= (func_q == FUNC_REQUEST) && calc_allowed;
      request_count <= (func_q == FUNC_REQUEST) ? count_next : '0;
    end
  end

  `FWRL_ASSERT_NEXT(a_accept_to_update, accept, state == ST_UPDATE, "accepted beat did not reach update")
  `FWRL_ASSERT_NOW(a_result_from_update, $rose(out_valid), $past(state) == ST_UPDATE, "result loaded outside update")
  `FWRL_ASSERT_NOW(a_allowed_counts, out_valid && allowed, request_count != '0, "allowed result with zero count")
  `FWRL_ASSERT_NOW(a_no_accept_while_clearing, table_busy, !accept, "item accepted during clearing sweep")

endmodule

### tb/fixed_window_rate_limiter_top_test.sv
// self-checking testbench for the fixed-window rate limiter top level
// depends on fwrl_pkg and fixed_window_rate_limiter_top; predicts every result
// beat from its own copy of the client table and checks it field by field
module fixed_window_rate_limiter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fwrl_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_ITEMS  = 95;

  typedef struct packed {
    logic               allowed;
    logic [COUNT_W-1:0] count;
  } verdict_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid;
  logic                   in_stall;
  logic                   func;
  logic [CLIENT_W-1:0]    client;
  logic [NOW_W-1:0]       now_seconds;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   allowed;
  logic [COUNT_W-1:0]     request_count;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  // predicted client table and limits
  logic                   live [256];
  logic [COUNT_W-1:0]     tally [256];
  logic [NOW_W-1:0]       opened [256];
  logic [CFG_W-1:0]       win_len = WINDOW_SECONDS_RESET;
  logic [CFG_W-1:0]       max_req = REQUEST_LIMIT_RESET;

  verdict_t    pending_verdicts [$];
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  fixed_window_rate_limiter_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .client        (client),
    .now_seconds   (now_seconds),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .allowed       (allowed),
    .request_count (request_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stall pattern in one of four modes, each picked at random
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= cycles[2] ^ cycles[0];
      endcase
    end
  end

  // one request or clear against the predicted table
  function automatic verdict_t limit_request(input logic op, input logic [CLIENT_W-1:0] idx,
                                             input logic [NOW_W-1:0] t);
    verdict_t         v;
    logic [NOW_W-1:0] elapsed;
    int unsigned      nxt;
    int unsigned      cap;
    if (op == FUNC_CLEAR) begin
      live[idx]  = 1'b0;
      tally[idx] = '0;
      v.allowed  = 1'b0;
      v.count    = '0;
      return v;
    end
    // unseen client opens a window now
    if (!live[idx]) begin
      live[idx]   = 1'b1;
      tally[idx]  = '0;
      opened[idx] = t;
    end
    // window expiry, elapsed wraps with the clock
    elapsed = t - opened[idx];
    if (elapsed >= {16'd0, win_len}) begin
      tally[idx]  = '0;
      opened[idx] = t;
    end
    // count saturates one above the maximum
    cap = max_req + 1;
    nxt = tally[idx] + 1;
    if (nxt > cap) nxt = cap;
    tally[idx] = nxt[COUNT_W-1:0];
    v.allowed  = (nxt <= max_req);
    v.count    = nxt[COUNT_W-1:0];
    return v;
  endfunction

  // result beats against the oldest prediction
  always @(posedge clk) begin : check_verdicts
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result beat: allowed %0b request_count %0d",
               allowed, request_count);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (allowed !== want.allowed) begin
          $error("allowed: expected %0b, got %0b", want.allowed, allowed);
          errors++;
        end
        if (request_count !== want.count) begin
          $error("request_count: expected %0d, got %0d", want.count, request_count);
          errors++;
        end
      end
    end
  end

  // one input beat, paced in bursts with random gaps
  task automatic send_item(input logic op, input logic [CLIENT_W-1:0] idx,
                           input logic [NOW_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    func        <= op;
    client      <= idx;
    now_seconds <= t;
    do @(posedge clk); while (in_stall);
    pending_verdicts.push_back(limit_request(op, idx, t));
  endtask

  // wait for every predicted result with the input idle
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write both limit registers while the block is idle
  task automatic set_limits(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] most);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_WINDOW_SECONDS;
    cfg_data  <= win;
    do @(posedge clk); while (!cfg_ready);
    win_len = win;
    cfg_index <= CFG_REQUEST_LIMIT;
    cfg_data  <= most;
    do @(posedge clk); while (!cfg_ready);
    max_req = most;
    cfg_valid <= 1'b0;
  endtask

  // reset limits: filling a window, wrap of the clock, expiry, clears
  task automatic test_default_windows();
    repeat (3) send_item(FUNC_REQUEST, 8'h00, 32'h0000_0000);
    send_item(FUNC_REQUEST, 8'hFF, 32'hFFFF_FFFF);
    send_item(FUNC_REQUEST, 8'hFF, 32'h0000_003A);
    send_item(FUNC_REQUEST, 8'hFF, 32'h0000_003B);
    send_item(FUNC_CLEAR,   8'h00, 32'h0000_0040);
    send_item(FUNC_REQUEST, 8'h00, 32'h0000_0041);
    send_item(FUNC_CLEAR,   8'h55, 32'h0000_0042);
    repeat (12) send_item(FUNC_REQUEST, 8'hAA, 32'h0000_0050);
  endtask

  // zero window restarts on each request, zero maximum denies all
  task automatic test_zero_settings();
    set_limits(16'd0, 16'd0);
    send_item(FUNC_REQUEST, 8'h01, 32'h0000_0005);
    send_item(FUNC_REQUEST, 8'h01, 32'h0000_0005);
  endtask

  // largest window and maximum
  task automatic test_wide_settings();
    set_limits(16'hFFFF, 16'hFFFF);
    send_item(FUNC_REQUEST, 8'h02, 32'h8000_0000);
    send_item(FUNC_REQUEST, 8'h02, 32'h8000_FFFE);
  endtask

  // stored count above the new cap is pulled down by the next request
  task automatic test_lowered_maximum();
    set_limits(16'd1000, 16'd20);
    repeat (5) send_item(FUNC_REQUEST, 8'h03, 32'h0000_000A);
    set_limits(16'd1000, 16'd2);
    send_item(FUNC_REQUEST, 8'h03, 32'h0000_000B);
  endtask

  // phases of random traffic from a small client pool on an advancing clock
  task automatic test_random_traffic();
    logic [CFG_W-1:0]    wins  [8] = '{16'd1, 16'hFFFF, 16'd0, 16'd7, 16'd60, 16'd300,
                                       16'd0, 16'd0};
    logic [CFG_W-1:0]    mosts [8] = '{16'd0, 16'hFFFF, 16'd3, 16'd2, 16'd10, 16'd1,
                                       16'd0, 16'd0};
    logic [CLIENT_W-1:0] pool [4];
    logic [NOW_W-1:0]    now_t;
    logic [CFG_W-1:0]    win;
    logic [CFG_W-1:0]    most;
    logic                op;
    logic [CLIENT_W-1:0] idx;
    int                  pick;
    for (int p = 0; p < 8; p++) begin
      win  = (p < 6) ? wins[p] : CFG_W'($urandom_range(0, 65535));
      most = (p < 6) ? mosts[p] : CFG_W'($urandom_range(0, 12));
      set_limits(win, most);
      foreach (pool[k]) pool[k] = CLIENT_W'($urandom_range(0, 255));
      now_t = (p == 2) ? 32'hFFFF_FF00 : $urandom();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        op  = ($urandom_range(0, 99) < 6) ? FUNC_CLEAR : FUNC_REQUEST;
        idx = ($urandom_range(0, 9) == 0) ? CLIENT_W'($urandom_range(0, 255))
                                          : pool[2'($urandom_range(0, 3))];
        pick = $urandom_range(0, 99);
        if (pick < 70) now_t += $urandom_range(0, 1);
        else if (pick < 95) now_t += $urandom_range(0, win + win / 2 + 2);
        else now_t = $urandom();
        send_item(op, idx, now_t);
      end
    end
  endtask

  initial begin
    in_valid    <= 1'b0;
    func        <= FUNC_REQUEST;
    client      <= '0;
    now_seconds <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_WINDOW_SECONDS;
    cfg_data    <= '0;
    foreach (live[k]) live[k] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_default_windows();
    test_zero_settings();
    test_wide_settings();
    test_lowered_maximum();
    test_random_traffic();

    drain_block();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
